// ===== hw/rtl/pmqb_pkg.sv =====
package pmqb_pkg;

  // Command codes carried by an input item.
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_DISPLAY = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Status codes carried by a result item.
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_OVERFLOW  = 2'd2,
    STS_BAD_QUEUE = 2'd3
  } status_t;

  // Kinds of work handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2
  } op_kind_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } back_state_t;

  // Input item payload.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         queue_sel;
    logic signed [31:0] item;
  } in_item_t;

  // Result item payload.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } out_item_t;

  // Width of the queue count register.
  localparam int NQ_WIDTH = 3;

  // Configuration write strobe toward the front end.
  typedef struct packed {
    logic                en;
    logic [NQ_WIDTH-1:0] num_queues;
  } cfg_wr_t;

  // Register index of the queue count register.
  localparam int REG_NUM_QUEUES = 0;

  // Depth of the operation queue between front and back end.
  localparam int OPQ_DEPTH = 2;

endpackage

// ===== hw/rtl/pmqb_front.sv =====
module pmqb_front #(
  parameter int STORE_DEPTH = 16,
  parameter int MAX_QUEUES  = 4,
  parameter int DATA_WIDTH  = 32,
  parameter type op_t       = logic
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pmqb_pkg::cfg_wr_t  cfg_wr,
  input  logic               in_valid,
  output logic               in_ready,
  input  pmqb_pkg::in_item_t in_data,
  output logic               op_push,
  output op_t                op_data,
  input  logic               op_full
);
  import pmqb_pkg::*;

  // Clamp a raw queue count to the supported range.
  function automatic int clamp_queues(input int k);
    int r;
    r = k;
    if (k == 0) begin
      r = 1;
    end else if (k > MAX_QUEUES) begin
      r = MAX_QUEUES;
    end
    return r;
  endfunction

  localparam int PW = $clog2(STORE_DEPTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);
  // Only four queues can be addressed by the two-bit selector.
  localparam int NQ = (MAX_QUEUES < 4) ? MAX_QUEUES : 4;
  localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;
  // Partition size for every raw value of the queue count register.
  localparam int PSZ [8] = '{
    STORE_DEPTH / clamp_queues(0), STORE_DEPTH / clamp_queues(1),
    STORE_DEPTH / clamp_queues(2), STORE_DEPTH / clamp_queues(3),
    STORE_DEPTH / clamp_queues(4), STORE_DEPTH / clamp_queues(5),
    STORE_DEPTH / clamp_queues(6), STORE_DEPTH / clamp_queues(7)
  };

  logic [NQ_WIDTH-1:0] active_r, active_nxt;
  logic [PW-1:0]       psz_r, psz_nxt;
  logic [PW-1:0]       head_r [NQ];
  logic [PW-1:0]       head_nxt [NQ];
  logic [PW-1:0]       tail_r [NQ];
  logic [PW-1:0]       tail_nxt [NQ];

  cmd_t          cmd;
  logic [1:0]    q;
  logic [QW-1:0] qi;
  logic          q_ok;
  logic [PW+1:0] base_full;
  logic [PW-1:0] base;
  logic [PW:0]   limit;
  logic [PW-1:0] h, t, h_inc, t_dec;
  logic          q_full, q_empty;
  logic          accept;

  // Classify the incoming item against its queue's pointers.
  assign cmd       = cmd_t'(in_data.cmd);
  assign q         = in_data.queue_sel;
  assign qi        = QW'(q);
  assign q_ok      = ({1'b0, q} < active_r);
  assign base_full = (PW+2)'(psz_r) * (PW+2)'(q);
  assign base      = base_full[PW-1:0];
  assign limit     = {1'b0, base} + {1'b0, psz_r};
  assign h         = head_r[qi];
  assign t         = tail_r[qi];
  assign h_inc     = h + PW'(1);
  assign t_dec     = t - PW'(1);
  assign q_full    = ({1'b0, t} >= limit) || (t >= PW'(STORE_DEPTH));
  assign q_empty   = (h >= t) || (h >= PW'(STORE_DEPTH));

  assign in_ready = !op_full && !cfg_wr.en;
  assign accept   = in_valid && in_ready;

  // Build the operation for the back end and update the queue pointers.
  always_comb begin
    op_push           = 1'b0;
    op_data           = '0;
    op_data.kind      = OP_STATUS;
    op_data.status    = STS_OK;
    active_nxt        = active_r;
    psz_nxt           = psz_r;
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    if (cfg_wr.en) begin
      active_nxt = NQ_WIDTH'(clamp_queues(int'(cfg_wr.num_queues)));
      psz_nxt    = PW'(PSZ[cfg_wr.num_queues]);
      for (int i = 0; i < NQ; i++) begin
        head_nxt[i] = PW'(int'(psz_nxt) * i);
        tail_nxt[i] = PW'(int'(psz_nxt) * i);
      end
    end else if (accept && cmd != CMD_NONE) begin
      op_push = 1'b1;
      if (!q_ok) begin
        op_data.status = STS_BAD_QUEUE;
      end else begin
        unique case (cmd)
          CMD_INSERT: begin
            if (q_full) begin
              op_data.status = STS_OVERFLOW;
            end else begin
              op_data.kind  = OP_WRITE;
              op_data.first = t[AW-1:0];
              op_data.wdata = DATA_WIDTH'($unsigned(in_data.item));
              tail_nxt[qi]  = t + PW'(1);
            end
          end
          CMD_DELETE: begin
            if (q_empty) begin
              op_data.status = STS_EMPTY;
            end else begin
              op_data.kind      = OP_READ;
              op_data.first     = h[AW-1:0];
              op_data.last_addr = h[AW-1:0];
              // A delete that empties the queue rewinds it to its base.
              if (h_inc >= t) begin
                head_nxt[qi] = base;
                tail_nxt[qi] = base;
              end else begin
                head_nxt[qi] = h_inc;
              end
            end
          end
          CMD_DISPLAY: begin
            if (q_empty) begin
              op_data.status = STS_EMPTY;
            end else begin
              op_data.kind      = OP_READ;
              op_data.first     = h[AW-1:0];
              op_data.last_addr = t_dec[AW-1:0];
            end
          end
          default: op_push = 1'b0;
        endcase
      end
    end
  end

  // Queue pointers and derived configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= NQ_WIDTH'(1);
      psz_r    <= PW'(STORE_DEPTH);
      for (int i = 0; i < NQ; i++) begin
        head_r[i] <= PW'(STORE_DEPTH * i);
        tail_r[i] <= PW'(STORE_DEPTH * i);
      end
    end else begin
      active_r <= active_nxt;
      psz_r    <= psz_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
    end
  end

`ifndef SYNTHESIS
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r[0] <= tail_r[0])
    else $error("queue 0 head passed its tail");
  a_tail_in_part: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r[0] <= psz_r)
    else $error("queue 0 tail ran past its partition");
`endif

endmodule

// ===== hw/rtl/pmqb_fifo.sv =====
module pmqb_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     pop_data,
  output logic empty
);
  import pmqb_pkg::*;

  localparam int PTRW = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int CW   = $clog2(OPQ_DEPTH + 1);

  T               mem_r [OPQ_DEPTH];
  logic [PTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full     = (count_r == CW'(OPQ_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTRW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTRW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("operation pushed into a full queue");
`endif

endmodule

// ===== hw/rtl/pmqb_back.sv =====
module pmqb_back #(
  parameter int STORE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32,
  parameter type op_t       = logic
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_valid,
  input  op_t                 op_data,
  output logic                op_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output pmqb_pkg::out_item_t out_data
);
  import pmqb_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  back_state_t             state_r, state_nxt;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic [AW-1:0]           end_r, end_nxt;
  logic [DATA_WIDTH-1:0]   store_r [STORE_DEPTH];
  logic [DATA_WIDTH-1:0]   rd_data_r;
  logic                    out_valid_r;
  out_item_t               out_r, out_nxt;
  logic                    out_free;
  logic                    load_out;
  logic                    wr_en, rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    at_end;

  assign out_free  = !out_valid_r || out_ready;
  assign at_end    = (ptr_r == end_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (op_valid && op_data.kind == OP_READ) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free && at_end) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Store accesses and result generation for the current state.
  always_comb begin
    op_pop   = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = op_data.first;
    load_out = 1'b0;
    out_nxt  = '0;
    ptr_nxt  = ptr_r;
    end_nxt  = end_r;
    unique case (state_r)
      BK_IDLE: begin
        if (op_valid) begin
          unique case (op_data.kind)
            OP_READ: begin
              // Start a read walk; the first word arrives next cycle.
              op_pop  = 1'b1;
              rd_en   = 1'b1;
              rd_addr = op_data.first;
              ptr_nxt = op_data.first;
              end_nxt = op_data.last_addr;
            end
            OP_WRITE: begin
              if (out_free) begin
                op_pop         = 1'b1;
                wr_en          = 1'b1;
                load_out       = 1'b1;
                out_nxt.status = STS_OK;
                out_nxt.last   = 1'b1;
              end
            end
            default: begin
              if (out_free) begin
                op_pop         = 1'b1;
                load_out       = 1'b1;
                out_nxt.status = op_data.status;
                out_nxt.last   = 1'b1;
              end
            end
          endcase
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          load_out       = 1'b1;
          out_nxt.status = STS_OK;
          out_nxt.data   = 32'($signed(rd_data_r));
          out_nxt.last   = at_end;
          if (!at_end) begin
            rd_en   = 1'b1;
            rd_addr = ptr_r + AW'(1);
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Shared store with one write and one registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[op_data.first] <= op_data.wdata;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  // Sequencer state and walk pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ptr_r <= ptr_nxt;
    end_r <= end_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("store written and read in the same cycle");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EMIT |-> ptr_r <= end_r)
    else $error("read walk passed its last address");
  a_read_used: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> state_r == BK_EMIT)
    else $error("read data issued with no word transfer pending");
`endif

endmodule

// ===== hw/rtl/partitioned_multi_queue_buffer.sv =====
// Up to four FIFO queues share one store of STORE_DEPTH words, split into equal
// linear partitions by the num_queues register (writing it empties every queue).
// A front end classifies each input transfer combinationally against the queue
// pointers and posts the work to a two-entry operation queue; a back end owns the
// single-port store and an output register. Insert, and every item that ends in
// a status only, pass through the back end at one per cycle while the output is
// free; a delete is a store read, then the result, and a display streams its words
// one per cycle behind the registered store read while the output is free.
// The store is not cleared after reset; only words that were inserted are read.
module partitioned_multi_queue_buffer #(
  parameter int STORE_DEPTH = 16,
  parameter int MAX_QUEUES  = 4,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  pmqb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pmqb_pkg::out_item_t out_data
);
  import pmqb_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  // Work item passed from the front end to the back end.
  typedef struct packed {
    op_kind_t              kind;
    status_t               status;
    logic [AW-1:0]         first;
    logic [AW-1:0]         last_addr;
    logic [DATA_WIDTH-1:0] wdata;
  } op_t;

  logic [NQ_WIDTH-1:0] nq_r;
  logic                reg_hit;
  cfg_wr_t             cfg_wr;
  logic                op_push, op_full, op_pop, op_empty;
  op_t                 op_in, op_out;

  // Register decode: one write per access phase.
  assign pready         = 1'b1;
  assign reg_hit        = (paddr[2] == 1'(REG_NUM_QUEUES));
  assign cfg_wr.en      = psel && penable && pwrite && pready && reg_hit;
  assign cfg_wr.num_queues = pwdata[NQ_WIDTH-1:0];
  assign prdata         = reg_hit ? 32'(nq_r) : '0;

  // Queue count register for readback.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nq_r <= NQ_WIDTH'(1);
    end else if (cfg_wr.en) begin
      nq_r <= cfg_wr.num_queues;
    end
  end

  pmqb_front #(
    .STORE_DEPTH(STORE_DEPTH),
    .MAX_QUEUES (MAX_QUEUES),
    .DATA_WIDTH (DATA_WIDTH),
    .op_t       (op_t)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .op_push (op_push),
    .op_data (op_in),
    .op_full (op_full)
  );

  pmqb_fifo #(
    .T(op_t)
  ) u_opq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (op_push),
    .push_data(op_in),
    .full     (op_full),
    .pop      (op_pop),
    .pop_data (op_out),
    .empty    (op_empty)
  );

  pmqb_back #(
    .STORE_DEPTH(STORE_DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .op_t       (op_t)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (!op_empty),
    .op_data  (op_out),
    .op_pop   (op_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== verif/tb_partitioned_multi_queue_buffer.sv =====
`timescale 1ns / 100ps

module tb_partitioned_multi_queue_buffer;
  import pmqb_pkg::*;

  localparam int STORE_WORDS = 16;
  localparam int QUEUE_SLOTS = 4;
  // Cycles allowed after the last result before the block is taken as idle.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  // Shadow copy of the queue state.
  logic [2:0] shadow_nq;
  logic [31:0] shadow_store [STORE_WORDS];
  int unsigned shadow_head [QUEUE_SLOTS];
  int unsigned shadow_tail [QUEUE_SLOTS];
  out_item_t predicted_results [$];

  int unsigned send_idle_pct = 16;
  int unsigned recv_stall_pct = 87;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  partitioned_multi_queue_buffer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Register values outside 1..4 act as the nearest legal count.
  function automatic int unsigned live_queues();
    if (shadow_nq == 0) return 1;
    if (shadow_nq > QUEUE_SLOTS) return QUEUE_SLOTS;
    return 32'(shadow_nq);
  endfunction

  function automatic int unsigned partition_words();
    return STORE_WORDS / live_queues();
  endfunction

  function automatic void empty_all_queues();
    int unsigned sz;
    sz = partition_words();
    for (int q = 0; q < QUEUE_SLOTS; q++) begin
      shadow_head[q] = sz * q;
      shadow_tail[q] = sz * q;
    end
  endfunction

  function automatic void set_queue_count(logic [2:0] value);
    shadow_nq = value;
    empty_all_queues();
  endfunction

  function automatic void push_result(status_t st, logic [31:0] word, logic fin);
    out_item_t r;
    r.status = st;
    r.data = word;
    r.last = fin;
    predicted_results.push_back(r);
  endfunction

  // Applies one accepted command to the shadow state and queues its results.
  function automatic void apply_queue_op(in_item_t op);
    int unsigned q;
    int unsigned sz;
    int unsigned base;
    int unsigned h;
    int unsigned t;
    q = 32'(op.queue_sel);
    if (op.cmd == CMD_NONE) return;
    if (q >= live_queues()) begin
      push_result(STS_BAD_QUEUE, '0, 1'b1);
      return;
    end
    sz = partition_words();
    base = sz * q;
    h = shadow_head[q];
    t = shadow_tail[q];
    case (op.cmd)
      CMD_INSERT: begin
        if (t >= base + sz) begin
          push_result(STS_OVERFLOW, '0, 1'b1);
        end else begin
          shadow_store[t] = op.item;
          shadow_tail[q] = t + 1;
          push_result(STS_OK, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (h >= t) begin
          push_result(STS_EMPTY, '0, 1'b1);
        end else begin
          push_result(STS_OK, shadow_store[h], 1'b1);
          // Emptying a queue rewinds both pointers to the partition base.
          if (h + 1 >= t) begin
            shadow_head[q] = base;
            shadow_tail[q] = base;
          end else begin
            shadow_head[q] = h + 1;
          end
        end
      end
      CMD_DISPLAY: begin
        if (h >= t) begin
          push_result(STS_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = h; i < t; i++) begin
            push_result(STS_OK, shadow_store[i], (i + 1 >= t));
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted input transfer updates the shadow state.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) apply_queue_op(in_data);
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.data, '0);
      end else begin
        want = predicted_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.data !== want.data)
          report_mismatch("data", out_data.data, want.data);
        if (out_data.last !== want.last)
          report_mismatch("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sends one command, with a random gap in front, and waits for its transfer.
  task automatic send_op(cmd_t c, logic [1:0] q, logic [31:0] word);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: c, queue_sel: q, item: word};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the sender off until every predicted result has arrived.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  // Writes the queue count once the block is idle.
  task automatic write_queue_count(logic [2:0] value);
    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_NUM_QUEUES);
    pwdata <= {29'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    set_queue_count(value);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Empty and invalid-queue cases, then inserts, a display and deletes, with the reset queue count.
  task automatic test_single_queue();
    send_op(CMD_DELETE, 2'd0, 32'h1234_5678);
    send_op(CMD_DISPLAY, 2'd0, 32'h0);
    send_op(CMD_INSERT, 2'd1, 32'hdead_beef);
    send_op(CMD_NONE, 2'd0, 32'hffff_ffff);
    send_op(CMD_INSERT, 2'd0, 32'h8000_0000);
    send_op(CMD_INSERT, 2'd0, 32'h7fff_ffff);
    send_op(CMD_DISPLAY, 2'd3, 32'h0);
    drain_outputs();
    send_op(CMD_DISPLAY, 2'd0, 32'h0);
    send_op(CMD_DELETE, 2'd0, 32'h0);
    send_op(CMD_DELETE, 2'd0, 32'h0);
  endtask

  // Full partition, overflow, unreused front slots and pointer rewind.
  task automatic test_partition_edges();
    write_queue_count(3'd4);
    send_op(CMD_INSERT, 2'd3, 32'h0000_0000);
    send_op(CMD_INSERT, 2'd3, 32'hffff_ffff);
    send_op(CMD_INSERT, 2'd3, 32'h5555_5555);
    send_op(CMD_INSERT, 2'd3, 32'haaaa_aaaa);
    send_op(CMD_INSERT, 2'd3, 32'h1111_1111);
    send_op(CMD_DELETE, 2'd3, 32'h0);
    send_op(CMD_INSERT, 2'd3, 32'h2222_2222);
    send_op(CMD_DISPLAY, 2'd3, 32'h0);
    send_op(CMD_DISPLAY, 2'd2, 32'h0);
    repeat (3) send_op(CMD_DELETE, 2'd3, 32'h0);
    send_op(CMD_INSERT, 2'd3, 32'h3333_3333);
    send_op(CMD_DISPLAY, 2'd3, 32'h0);
  endtask

  // Random traffic over three queue counts, with runs that lean toward filling
  // or toward draining so that queues reach both full and empty.
  task automatic test_random_mix(int unsigned sender_pct, int unsigned stall_pct,
                                 int unsigned total, logic [8:0] counts);
    int unsigned done;
    int unsigned run_left;
    int unsigned r;
    bit grow;
    logic [1:0] q;
    cmd_t c;
    send_idle_pct = sender_pct;
    recv_stall_pct = stall_pct;
    for (int round = 0; round < 3; round++) begin
      write_queue_count(counts[3 * round +: 3]);
      done = 0;
      grow = 1'b1;
      run_left = $urandom_range(20, 8);
      while (done < total / 3) begin
        if (run_left == 0) begin
          grow = !grow;
          run_left = $urandom_range(20, 8);
        end
        run_left--;
        if ($urandom_range(99) < 85) q = 2'($urandom_range(live_queues() - 1));
        else q = 2'($urandom_range(3));
        r = $urandom_range(99);
        if (r < 5) c = CMD_NONE;
        else if (r < (grow ? 60 : 25)) c = CMD_INSERT;
        else if (r < 85) c = CMD_DELETE;
        else c = CMD_DISPLAY;
        send_op(c, q, random_word());
        if (c != CMD_NONE) done++;
        if ($urandom_range(99) < 3) drain_outputs();
      end
    end
  endtask

  initial begin
    set_queue_count(3'd1);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_single_queue();
    test_partition_edges();
    test_random_mix(16, 87, 120, {3'd1, 3'd0, 3'd4});
    test_random_mix(87, 16, 120, {3'd3, 3'd7, 3'd2});
    test_random_mix(0, 0, 120, {3'd1, 3'd6, 3'd5});
    drain_outputs();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pmqb_pkg.sv
hw/rtl/pmqb_front.sv
hw/rtl/pmqb_fifo.sv
hw/rtl/pmqb_back.sv
hw/rtl/partitioned_multi_queue_buffer.sv
verif/tb_partitioned_multi_queue_buffer.sv
